// ===== rtl/tone_script_sequencer_core_defines.svh =====
// Assertion macros used by the sequencer core RTL.
`ifndef TONE_SCRIPT_SEQUENCER_CORE_DEFINES_SVH
`define TONE_SCRIPT_SEQUENCER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is high.
`define TSS_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("tone script sequencer: check failed");

// Next-cycle implication, disabled while reset is high.
`define TSS_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("tone script sequencer: check failed");

`else

`define TSS_ASSERT_IMP(label, clk, rst, pre, post)
`define TSS_ASSERT_NXT(label, clk, rst, pre, post)

`endif

`endif

// ===== rtl/tss_pkg.sv =====
package tss_pkg;

   // Field widths of the request and response transactions and of the CSR port.
   localparam int ACTION_W   = 2;
   localparam int ENTRY_W    = 8;
   localparam int FREQ_W     = 16;
   localparam int TICKS_W    = 16;
   localparam int PERIOD_W   = 32;
   localparam int PULSE_W    = 31;
   localparam int CLOCK_HZ_W = 32;
   localparam int NOTES_W    = 9;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;

   // Request action codes.
   localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_START = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_STOP  = 2'd3;

   // Register indexes of the CSR write port.
   localparam logic [CSR_IDX_W-1:0] CSR_CLOCK_HZ   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOTE_COUNT = 1'b1;

   // Register reset values.
   localparam logic [CLOCK_HZ_W-1:0] CLOCK_HZ_RESET   = 32'd16000000;
   localparam logic [NOTES_W-1:0]    NOTE_COUNT_RESET = 9'd1;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   // Status from the divider back to the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== rtl/tss_req_if.sv =====
interface tss_req_if;
   import tss_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [ENTRY_W-1:0]  entry_index;
   logic [FREQ_W-1:0]   entry_freq;
   logic [TICKS_W-1:0]  entry_ticks;

   modport source (output valid, action, entry_index, entry_freq, entry_ticks,
                   input ready);
   modport sink (input valid, action, entry_index, entry_freq, entry_ticks,
                 output ready);
endinterface

// ===== rtl/tss_rsp_if.sv =====
interface tss_rsp_if;
   import tss_pkg::*;

   logic                valid;
   logic                ready;
   logic [PERIOD_W-1:0] pwm_period;
   logic [PULSE_W-1:0]  pwm_pulse;
   logic                pwm_enable;
   logic                note_loaded;
   logic                melody_done;

   modport source (output valid, pwm_period, pwm_pulse, pwm_enable, note_loaded,
                   melody_done, input ready);
   modport sink (input valid, pwm_period, pwm_pulse, pwm_enable, note_loaded,
                 melody_done, output ready);
endinterface

// ===== rtl/tone_script_sequencer_core.sv =====
// Tone script sequencer: plays a stored script of notes on a PWM buzzer. Each
// request transaction (tick, write, start or stop) yields exactly one response
// transaction carrying the current PWM period, pulse and enable plus flags for
// a note load and for the end of the melody. Script entries live in one
// synchronous RAM of SCRIPT_DEPTH words and must be written before they are
// played. Requests are taken one at a time: a write, start, stop or a tick
// that only counts down goes from acceptance to the emit state, which loads
// the response register; a tick that loads a rest note first passes the RAM
// read state, and a tick that loads a sounding note passes the RAM read and
// the bit-serial divider that computes period = clock_hz / freq (the pulse is
// half of that quotient, rounded down). The emit state waits while a previous
// response still waits in the output register. A new request is accepted
// while the previous response still waits in the output register.
// The CSR registers clock_hz and note_count must only be written while no
// request is in progress.
`include "tone_script_sequencer_core_defines.svh"

module tone_script_sequencer_core #(
   parameter int SCRIPT_DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   tss_req_if.sink                          req_if,
   tss_rsp_if.source                        rsp_if,
   input  logic                             csr_we,
   input  logic [tss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tss_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tss_pkg::*;

   localparam int ADDR_W = $clog2(SCRIPT_DEPTH);
   localparam int WORD_W = FREQ_W + TICKS_W;

   // Architectural state.
   state_type             state_ff, state_in;
   logic [CLOCK_HZ_W-1:0] clock_hz_ff;
   logic [NOTES_W-1:0]    note_count_ff;
   logic [ADDR_W-1:0]     play_index_ff, play_index_in;
   logic [TICKS_W-1:0]    countdown_ff, countdown_in;
   logic                  playing_ff, playing_in;
   logic [PERIOD_W-1:0]   period_ff, period_in;
   logic [PULSE_W-1:0]    pulse_ff, pulse_in;

   // Flags of the transaction in progress.
   logic                  loaded_ff, loaded_in;
   logic                  done_ff, done_in;

   // Response register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PERIOD_W-1:0]   rsp_period_ff, rsp_period_in;
   logic [PULSE_W-1:0]    rsp_pulse_ff, rsp_pulse_in;
   logic                  rsp_enable_ff, rsp_enable_in;
   logic                  rsp_loaded_ff, rsp_loaded_in;
   logic                  rsp_done_ff, rsp_done_in;

   // Script RAM and divider connections.
   logic                  ram_we;
   logic                  ram_re;
   logic [WORD_W-1:0]     ram_rdata;
   logic [FREQ_W-1:0]     rd_freq;
   logic [TICKS_W-1:0]    rd_ticks;
   logic                  div_start;
   div_status_type        div_status;
   logic [PERIOD_W-1:0]   div_quotient;

   logic                  req_accept;
   logic                  rsp_free;
   logic                  finish;
   logic [31:0]           next_index;
   logic [31:0]           end_count;

   assign rd_freq  = ram_rdata[WORD_W-1:TICKS_W];
   assign rd_ticks = ram_rdata[TICKS_W-1:0];

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;

   // The melody ends once the next index reaches note_count, capped at the
   // script depth.
   assign next_index = 32'(play_index_ff) + 32'd1;
   assign end_count  = (32'(note_count_ff) > 32'(SCRIPT_DEPTH)) ?
                       32'(SCRIPT_DEPTH) : 32'(note_count_ff);

   tss_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SCRIPT_DEPTH)
   ) u_script_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ADDR_W'(req_if.entry_index)),
      .wdata ({req_if.entry_freq, req_if.entry_ticks}),
      .re    (ram_re),
      .raddr (play_index_ff),
      .rdata (ram_rdata)
   );

   tss_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (clock_hz_ff),
      .divisor  (rd_freq),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // Sequencer next state and datapath updates.
   always_comb begin
      state_in      = state_ff;
      play_index_in = play_index_ff;
      countdown_in  = countdown_ff;
      playing_in    = playing_ff;
      period_in     = period_ff;
      pulse_in      = pulse_ff;
      loaded_in     = loaded_ff;
      done_in       = done_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_period_in = rsp_period_ff;
      rsp_pulse_in  = rsp_pulse_ff;
      rsp_enable_in = rsp_enable_ff;
      rsp_loaded_in = rsp_loaded_ff;
      rsp_done_in   = rsp_done_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      div_start     = 1'b0;
      finish        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               loaded_in = 1'b0;
               done_in   = 1'b0;
               state_in  = ST_EMIT;
               unique case (req_if.action)
                  ACT_WRITE: begin
                     ram_we = (32'(req_if.entry_index) < 32'(SCRIPT_DEPTH));
                  end
                  ACT_START: begin
                     playing_in = 1'b1;
                  end
                  ACT_STOP: begin
                     playing_in    = 1'b0;
                     play_index_in = '0;
                  end
                  ACT_TICK: begin
                     if (playing_ff) begin
                        if (countdown_ff == '0) begin
                           ram_re   = 1'b1;
                           state_in = ST_READ;
                        end else begin
                           countdown_in = countdown_ff - TICKS_W'(1);
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            // A rest silences the buzzer and keeps the period.
            if (rd_freq == '0) begin
               pulse_in = '0;
               finish   = 1'b1;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               period_in = div_quotient;
               pulse_in  = div_quotient[PERIOD_W-1:1];
               finish    = 1'b1;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_period_in = period_ff;
               rsp_pulse_in  = pulse_ff;
               rsp_enable_in = playing_ff;
               rsp_loaded_in = loaded_ff;
               rsp_done_in   = done_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Completion of a note load: advance, or stop and rewind after the last.
      if (finish) begin
         loaded_in    = 1'b1;
         countdown_in = rd_ticks;
         state_in     = ST_EMIT;
         if (next_index >= end_count) begin
            playing_in    = 1'b0;
            play_index_in = '0;
            countdown_in  = '0;
            done_in       = 1'b1;
         end else begin
            play_index_in = ADDR_W'(next_index);
         end
      end
   end

   // Control and architectural registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         clock_hz_ff   <= CLOCK_HZ_RESET;
         note_count_ff <= NOTE_COUNT_RESET;
         play_index_ff <= '0;
         countdown_ff  <= '0;
         playing_ff    <= 1'b0;
         period_ff     <= '0;
         pulse_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         play_index_ff <= play_index_in;
         countdown_ff  <= countdown_in;
         playing_ff    <= playing_in;
         period_ff     <= period_in;
         pulse_ff      <= pulse_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_CLOCK_HZ:   clock_hz_ff   <= csr_wdata[CLOCK_HZ_W-1:0];
               CSR_NOTE_COUNT: note_count_ff <= csr_wdata[NOTES_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      loaded_ff     <= loaded_in;
      done_ff       <= done_in;
      rsp_period_ff <= rsp_period_in;
      rsp_pulse_ff  <= rsp_pulse_in;
      rsp_enable_ff <= rsp_enable_in;
      rsp_loaded_ff <= rsp_loaded_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.pwm_period  = rsp_period_ff;
   assign rsp_if.pwm_pulse   = rsp_pulse_ff;
   assign rsp_if.pwm_enable  = rsp_enable_ff;
   assign rsp_if.note_loaded = rsp_loaded_ff;
   assign rsp_if.melody_done = rsp_done_ff;

   // A finished melody is a load that also turned playing off.
   `TSS_ASSERT_IMP(a_done_means_stopped, clock, reset, rsp_if.valid && rsp_if.melody_done, rsp_if.note_loaded && !rsp_if.pwm_enable)

   // The divider is only started on a sounding note just read from the script.
   `TSS_ASSERT_IMP(a_div_start_on_note, clock, reset, div_start, state_ff == ST_READ && rd_freq != '0)

   // A divider result is only produced while the sequencer waits for it.
   `TSS_ASSERT_IMP(a_div_done_waited, clock, reset, div_status.done, state_ff == ST_DIVIDE)

   // The divider only runs while the sequencer waits for its quotient.
   `TSS_ASSERT_IMP(a_div_busy_waited, clock, reset, div_status.busy, state_ff == ST_DIVIDE)

   // A tick at the end of a note reads the next script entry.
   `TSS_ASSERT_NXT(a_tick_reads_entry, clock, reset, req_accept && req_if.action == ACT_TICK && playing_ff && countdown_ff == '0, state_ff == ST_READ)

endmodule

// ===== rtl/tss_ram.sv =====
module tss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/tss_divider.sv =====
module tss_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [tss_pkg::PERIOD_W-1:0]   dividend,
   input  logic [tss_pkg::FREQ_W-1:0]     divisor,
   output tss_pkg::div_status_type        status,
   output logic [tss_pkg::PERIOD_W-1:0]   quotient
);
   import tss_pkg::*;

   localparam int CNT_W = $clog2(PERIOD_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [PERIOD_W-1:0] shift_ff, shift_in;
   logic [FREQ_W-1:0]   rem_ff, rem_in;
   logic [FREQ_W-1:0]   dsr_ff, dsr_in;
   logic [FREQ_W:0]     trial;

   // Restoring division, one quotient bit per cycle. The dividend shifts out
   // of the top of shift_ff while quotient bits shift in at the bottom.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      trial    = {rem_ff, shift_ff[PERIOD_W-1]};
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(PERIOD_W - 1);
         shift_in = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in   = FREQ_W'(trial - {1'b0, dsr_ff});
            shift_in = {shift_ff[PERIOD_W-2:0], 1'b1};
         end else begin
            rem_in   = trial[FREQ_W-1:0];
            shift_in = {shift_ff[PERIOD_W-2:0], 1'b0};
         end
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = shift_ff;

endmodule

// ===== tb/sv/tb_tone_script_sequencer_core.sv =====
module tb_tone_script_sequencer_core;
   import tss_pkg::*;

   localparam int SCRIPT_DEPTH    = 256;
   localparam int ITEM_TARGET     = 1550;
   localparam int QUIET_FROM      = 1300;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int DRAIN_CYCLES    = 60;

   // One request transaction and one response transaction at the block's widths.
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [ENTRY_W-1:0]  idx;
      logic [FREQ_W-1:0]   freq;
      logic [TICKS_W-1:0]  ticks;
   } note_req_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic [PULSE_W-1:0]  pulse;
      logic                enable;
      logic                loaded;
      logic                done;
   } pwm_rsp_type;

   typedef enum logic [1:0] {
      ROW_REQ,
      ROW_CHECKED,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   csr_sel;
      logic [CSR_DATA_W-1:0]  csr_val;
      note_req_type           req;
      pwm_rsp_type            want;
   } script_row_type;

   localparam note_req_type NO_REQ = '0;
   localparam pwm_rsp_type  NO_PWM = '0;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tss_req_if note_req_if ();
   tss_rsp_if pwm_rsp_if ();

   tone_script_sequencer_core #(
      .SCRIPT_DEPTH(SCRIPT_DEPTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (note_req_if),
      .rsp_if    (pwm_rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Player state mirrored by the testbench.
   logic [FREQ_W-1:0]     plr_freq [SCRIPT_DEPTH];
   logic [TICKS_W-1:0]    plr_ticks [SCRIPT_DEPTH];
   logic [ENTRY_W-1:0]    plr_index;
   logic [TICKS_W-1:0]    plr_countdown;
   logic                  plr_playing;
   logic [PERIOD_W-1:0]   plr_period;
   logic [PULSE_W-1:0]    plr_pulse;
   logic [CLOCK_HZ_W-1:0] cfg_clock_hz;
   logic [NOTES_W-1:0]    cfg_note_count;

   pwm_rsp_type expected_pwm [$];
   int          items_sent;
   int          fail_count;
   bit          quiet;

   // Directed script: extremes, every action, and the corner cases of playback.
   script_row_type directed_rows [0:31] = '{
      '{ROW_CHECKED, CSR_CLOCK_HZ, 32'd0, '{ACT_TICK, 8'h00, 16'h0000, 16'h0000}, NO_PWM},
      '{ROW_CHECKED, CSR_CLOCK_HZ, 32'd0, '{ACT_STOP, 8'hFF, 16'hFFFF, 16'hFFFF}, NO_PWM},
      '{ROW_CHECKED, CSR_CLOCK_HZ, 32'd0, '{ACT_WRITE, 8'h00, 16'hFFFF, 16'h0000}, NO_PWM},
      '{ROW_CHECKED, CSR_CLOCK_HZ, 32'd0, '{ACT_WRITE, 8'hFF, 16'h0000, 16'hFFFF}, NO_PWM},
      '{ROW_CHECKED, CSR_CLOCK_HZ, 32'd0, '{ACT_WRITE, 8'h01, 16'h0001, 16'h0001}, NO_PWM},
      '{ROW_CHECKED, CSR_CLOCK_HZ, 32'd0, '{ACT_START, 8'hAA, 16'h5555, 16'hAAAA},
        '{32'd0, 31'd0, 1'b1, 1'b0, 1'b0}},
      '{ROW_CHECKED, CSR_CLOCK_HZ, 32'd0, '{ACT_START, 8'h55, 16'hAAAA, 16'h5555},
        '{32'd0, 31'd0, 1'b1, 1'b0, 1'b0}},
      '{ROW_CHECKED, CSR_CLOCK_HZ, 32'd0, '{ACT_TICK, 8'h00, 16'h0000, 16'h0000},
        '{32'd244, 31'd122, 1'b0, 1'b1, 1'b1}},
      '{ROW_CSR, CSR_NOTE_COUNT, 32'd256, NO_REQ, NO_PWM},
      '{ROW_CSR, CSR_CLOCK_HZ, 32'hFFFF_FFFF, NO_REQ, NO_PWM},
      '{ROW_CHECKED, CSR_CLOCK_HZ, 32'd0, '{ACT_START, 8'h00, 16'h0000, 16'h0000},
        '{32'd244, 31'd122, 1'b1, 1'b0, 1'b0}},
      '{ROW_CHECKED, CSR_CLOCK_HZ, 32'd0, '{ACT_TICK, 8'h00, 16'h0000, 16'h0000},
        '{32'd65537, 31'd32768, 1'b1, 1'b1, 1'b0}},
      '{ROW_CHECKED, CSR_CLOCK_HZ, 32'd0, '{ACT_TICK, 8'h00, 16'h0000, 16'h0000},
        '{32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1'b1, 1'b0}},
      // Stop in the middle of a note keeps the remaining countdown.
      '{ROW_CHECKED, CSR_CLOCK_HZ, 32'd0, '{ACT_STOP, 8'h00, 16'h0000, 16'h0000},
        '{32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b0, 1'b0, 1'b0}},
      '{ROW_REQ, CSR_CLOCK_HZ, 32'd0, '{ACT_START, 8'h00, 16'h0000, 16'h0000}, NO_PWM},
      '{ROW_REQ, CSR_CLOCK_HZ, 32'd0, '{ACT_TICK, 8'hFF, 16'hFFFF, 16'hFFFF}, NO_PWM},
      '{ROW_REQ, CSR_CLOCK_HZ, 32'd0, '{ACT_TICK, 8'h00, 16'h0000, 16'h0000}, NO_PWM},
      '{ROW_REQ, CSR_CLOCK_HZ, 32'd0, '{ACT_WRITE, 8'h02, 16'h0000, 16'h0002}, NO_PWM},
      '{ROW_REQ, CSR_CLOCK_HZ, 32'd0, '{ACT_TICK, 8'h00, 16'h0000, 16'h0000}, NO_PWM},
      '{ROW_REQ, CSR_CLOCK_HZ, 32'd0, '{ACT_TICK, 8'h00, 16'h0000, 16'h0000}, NO_PWM},
      // Shrinking the note count below the index ends the melody at the next load.
      '{ROW_CSR, CSR_NOTE_COUNT, 32'd1, NO_REQ, NO_PWM},
      '{ROW_CSR, CSR_CLOCK_HZ, 32'd0, NO_REQ, NO_PWM},
      '{ROW_CHECKED, CSR_CLOCK_HZ, 32'd0, '{ACT_TICK, 8'h00, 16'h0000, 16'h0000},
        '{32'hFFFF_FFFF, 31'd0, 1'b0, 1'b1, 1'b1}},
      '{ROW_CSR, CSR_NOTE_COUNT, 32'd0, NO_REQ, NO_PWM},
      '{ROW_REQ, CSR_CLOCK_HZ, 32'd0, '{ACT_START, 8'h00, 16'h0000, 16'h0000}, NO_PWM},
      '{ROW_CHECKED, CSR_CLOCK_HZ, 32'd0, '{ACT_TICK, 8'h00, 16'h0000, 16'h0000},
        '{32'd0, 31'd0, 1'b0, 1'b1, 1'b1}},
      '{ROW_CSR, CSR_NOTE_COUNT, 32'd511, NO_REQ, NO_PWM},
      '{ROW_CSR, CSR_CLOCK_HZ, 32'd1, NO_REQ, NO_PWM},
      '{ROW_REQ, CSR_CLOCK_HZ, 32'd0, '{ACT_START, 8'h00, 16'h0000, 16'h0000}, NO_PWM},
      '{ROW_REQ, CSR_CLOCK_HZ, 32'd0, '{ACT_TICK, 8'h00, 16'h0000, 16'h0000}, NO_PWM},
      '{ROW_REQ, CSR_CLOCK_HZ, 32'd0, '{ACT_TICK, 8'h00, 16'h0000, 16'h0000}, NO_PWM},
      '{ROW_REQ, CSR_CLOCK_HZ, 32'd0, '{ACT_STOP, 8'h00, 16'h0000, 16'h0000}, NO_PWM}
   };

   // Clock with a period of 10.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Steps the player by one request and returns the response it produces.
   function automatic pwm_rsp_type advance_player(input note_req_type r);
      pwm_rsp_type       o;
      logic [FREQ_W-1:0] f;
      logic [8:0]        nxt;
      logic [8:0]        last;
      o = NO_PWM;
      case (r.action)
         ACT_WRITE: begin
            plr_freq[r.idx]  = r.freq;
            plr_ticks[r.idx] = r.ticks;
         end
         ACT_START: plr_playing = 1'b1;
         ACT_STOP: begin
            plr_playing = 1'b0;
            plr_index   = '0;
         end
         ACT_TICK: begin
            if (plr_playing && plr_countdown == '0) begin
               f             = plr_freq[plr_index];
               plr_countdown = plr_ticks[plr_index];
               if (f == '0) begin
                  plr_pulse = '0;
               end else begin
                  plr_period = cfg_clock_hz / 32'(f);
                  plr_pulse  = 31'((cfg_clock_hz >> 1) / 32'(f));
               end
               o.loaded = 1'b1;
               nxt  = 9'(plr_index) + 9'd1;
               last = (cfg_note_count > 9'(SCRIPT_DEPTH)) ? 9'(SCRIPT_DEPTH) : cfg_note_count;
               if (nxt >= last) begin
                  plr_playing   = 1'b0;
                  plr_index     = '0;
                  plr_countdown = '0;
                  o.done        = 1'b1;
               end else begin
                  plr_index = nxt[ENTRY_W-1:0];
               end
            end else if (plr_playing) begin
               plr_countdown = plr_countdown - TICKS_W'(1);
            end
         end
         default: ;
      endcase
      o.period = plr_period;
      o.pulse  = plr_pulse;
      o.enable = plr_playing;
      return o;
   endfunction

   function automatic note_req_type make_req(input logic [ACTION_W-1:0] act,
                                             input logic [ENTRY_W-1:0] idx,
                                             input logic [FREQ_W-1:0] freq,
                                             input logic [TICKS_W-1:0] ticks);
      note_req_type r;
      r.action = act;
      r.idx    = idx;
      r.freq   = freq;
      r.ticks  = ticks;
      return r;
   endfunction

   // Presents one request transaction, waits for it to be taken, and queues its response.
   task automatic issue(input note_req_type r, input bit use_typed,
                        input pwm_rsp_type typed_rsp);
      int          gap;
      pwm_rsp_type predicted;
      gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
         note_req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      note_req_if.valid       <= 1'b1;
      note_req_if.action      <= r.action;
      note_req_if.entry_index <= r.idx;
      note_req_if.entry_freq  <= r.freq;
      note_req_if.entry_ticks <= r.ticks;
      do @(posedge clock); while (!note_req_if.ready);
      predicted = advance_player(r);
      expected_pwm.push_back(use_typed ? typed_rsp : predicted);
      items_sent++;
      if (items_sent >= QUIET_FROM) quiet = 1'b1;
   endtask

   // Control actions carry random values in the fields that they ignore.
   task automatic send_control(input logic [ACTION_W-1:0] act);
      issue(make_req(act, ENTRY_W'($urandom), FREQ_W'($urandom), TICKS_W'($urandom)),
            1'b0, NO_PWM);
   endtask

   // Register writes happen only once every pending response has been delivered.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] sel, input logic [CSR_DATA_W-1:0] val);
      note_req_if.valid <= 1'b0;
      while (expected_pwm.size() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= val;
      @(posedge clock);
      if (sel == CSR_CLOCK_HZ) cfg_clock_hz = val;
      else cfg_note_count = val[NOTES_W-1:0];
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Response checker: every accepted response is compared with the oldest prediction.
   always @(posedge clock) begin : check_pwm
      pwm_rsp_type want;
      if (!reset && pwm_rsp_if.valid && pwm_rsp_if.ready) begin
         if (expected_pwm.size() == 0) begin
            $error("response transaction with no request pending");
            fail_count++;
         end else begin
            want = expected_pwm.pop_front();
            if (pwm_rsp_if.pwm_period !== want.period) begin
               $error("pwm_period: expected %0d, got %0d", want.period, pwm_rsp_if.pwm_period);
               fail_count++;
            end
            if (pwm_rsp_if.pwm_pulse !== want.pulse) begin
               $error("pwm_pulse: expected %0d, got %0d", want.pulse, pwm_rsp_if.pwm_pulse);
               fail_count++;
            end
            if (pwm_rsp_if.pwm_enable !== want.enable) begin
               $error("pwm_enable: expected %0d, got %0d", want.enable, pwm_rsp_if.pwm_enable);
               fail_count++;
            end
            if (pwm_rsp_if.note_loaded !== want.loaded) begin
               $error("note_loaded: expected %0d, got %0d", want.loaded,
                      pwm_rsp_if.note_loaded);
               fail_count++;
            end
            if (pwm_rsp_if.melody_done !== want.done) begin
               $error("melody_done: expected %0d, got %0d", want.done, pwm_rsp_if.melody_done);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: too many cycles without any transaction on either channel ends the run.
   always @(posedge clock) begin : watchdog
      int idle_cycles;
      if ((note_req_if.valid && note_req_if.ready) || (pwm_rsp_if.valid && pwm_rsp_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Response side backpressure: random stall bursts, none in the last part of the run.
   initial begin : pwm_sink_pace
      int run;
      pwm_rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            pwm_rsp_if.ready <= 1'b0;
            run = $urandom_range(1, 6);
         end else begin
            pwm_rsp_if.ready <= 1'b1;
            run = $urandom_range(1, 12);
         end
         repeat (run) @(posedge clock);
      end
   end

   // Main stimulus: directed script first, then random melodies under random settings.
   initial begin : stimulus
      int                      r;
      int                      mel_end;
      int                      phase;
      logic [CLOCK_HZ_W-1:0]   clk_val;
      logic [NOTES_W-1:0]      notes;
      logic [FREQ_W-1:0]       fr;
      logic [TICKS_W-1:0]      tk;

      reset                   <= 1'b1;
      csr_we                  <= 1'b0;
      csr_index               <= CSR_CLOCK_HZ;
      csr_wdata               <= '0;
      note_req_if.valid       <= 1'b0;
      note_req_if.action      <= ACT_TICK;
      note_req_if.entry_index <= '0;
      note_req_if.entry_freq  <= '0;
      note_req_if.entry_ticks <= '0;
      cfg_clock_hz   = CLOCK_HZ_RESET;
      cfg_note_count = NOTE_COUNT_RESET;
      plr_index      = '0;
      plr_countdown  = '0;
      plr_playing    = 1'b0;
      plr_period     = '0;
      plr_pulse      = '0;
      items_sent     = 0;
      fail_count     = 0;
      quiet          = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_CSR: write_csr(directed_rows[i].csr_sel, directed_rows[i].csr_val);
            ROW_CHECKED: issue(directed_rows[i].req, 1'b1, directed_rows[i].want);
            default: issue(directed_rows[i].req, 1'b0, NO_PWM);
         endcase
      end

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         // Pick the settings for this melody.
         r = $urandom_range(0, 99);
         if (r < 30) clk_val = CLOCK_HZ_RESET;
         else if (r < 55) clk_val = $urandom;
         else if (r < 70) clk_val = '1;
         else if (r < 90) clk_val = CLOCK_HZ_W'($urandom_range(1, 5000));
         else clk_val = '0;
         r = $urandom_range(0, 99);
         if (phase == 3) begin
            notes = $urandom_range(0, 1) ? 9'd256 : NOTES_W'($urandom_range(257, 511));
         end
         else if (r < 60) notes = NOTES_W'($urandom_range(1, 6));
         else if (r < 85) notes = NOTES_W'($urandom_range(7, 16));
         else if (r < 93) notes = '0;
         else notes = NOTES_W'($urandom_range(17, 48));
         write_csr(CSR_CLOCK_HZ, clk_val);
         write_csr(CSR_NOTE_COUNT, CSR_DATA_W'(notes));
         mel_end = (notes == 0) ? 1 : ((notes > SCRIPT_DEPTH) ? SCRIPT_DEPTH : notes);

         // Fill every entry that the melody will play.
         for (int i = 0; i < mel_end; i++) begin
            r = $urandom_range(0, 99);
            if (r < 10) fr = '0;
            else if (r < 50) fr = FREQ_W'($urandom_range(1, 300));
            else if (r < 60) fr = '1;
            else fr = FREQ_W'($urandom);
            if (mel_end > 48) tk = '0;
            else if ($urandom_range(0, 99) < 80) tk = TICKS_W'($urandom_range(0, 2));
            else tk = TICKS_W'($urandom_range(3, 25));
            issue(make_req(ACT_WRITE, ENTRY_W'(i), fr, tk), 1'b0, NO_PWM);
         end
         if ($urandom_range(0, 3) == 0) send_control($urandom_range(0, 1) ? ACT_TICK : ACT_STOP);
         send_control(ACT_START);

         // Play it out, with occasional restarts, stops and writes outside the melody.
         while (plr_playing) begin
            r = $urandom_range(0, 99);
            if (r < 88) begin
               send_control(ACT_TICK);
            end else if (r < 91) begin
               send_control(ACT_START);
            end else if (r < 96 && mel_end < SCRIPT_DEPTH) begin
               issue(make_req(ACT_WRITE, ENTRY_W'($urandom_range(mel_end, SCRIPT_DEPTH - 1)),
                              FREQ_W'($urandom), TICKS_W'($urandom)), 1'b0, NO_PWM);
            end else if (r < 96) begin
               send_control(ACT_TICK);
            end else begin
               send_control(ACT_STOP);
               if ($urandom_range(0, 1) == 0) send_control(ACT_TICK);
               if ($urandom_range(0, 1) == 0) send_control(ACT_START);
            end
         end
         phase++;
      end

      // Drain the remaining responses and let the block settle.
      note_req_if.valid <= 1'b0;
      while (expected_pwm.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== tone_script_sequencer_core.f =====
+incdir+rtl
rtl/tss_pkg.sv
rtl/tss_req_if.sv
rtl/tss_rsp_if.sv
rtl/tss_ram.sv
rtl/tss_divider.sv
rtl/tone_script_sequencer_core.sv
tb/sv/tb_tone_script_sequencer_core.sv
